FILE: hdl/tre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tre_pkg: shared types and constants of the RSSI envelope and link quality
// monitor.
// Holds the transaction payloads, event codes, register indexes and reset
// values.
// -----------------------------------------------------------------------------
package tre_pkg;

	typedef enum logic [1:0] {
		CMD_TELEMETRY = 2'd0,
		CMD_SYNC      = 2'd1,
		CMD_DWELL_END = 2'd2,
		CMD_RESTART   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		REG_UID3     = 4'd0,
		REG_UID4     = 4'd1,
		REG_UID5     = 4'd2,
		REG_MASK     = 4'd3,
		REG_FLOOR    = 4'd4,
		REG_DECAY    = 4'd5,
		REG_GATE     = 4'd6,
		REG_INTERVAL = 4'd7
	} reg_idx_t;

	localparam logic [7:0]        MASK_RESET     = 8'd192;
	localparam logic signed [7:0] FLOOR_RESET    = -8'sd110;
	localparam logic [6:0]        DECAY_RESET    = 7'd2;
	localparam logic [15:0]       GATE_RESET     = 16'd5000;
	localparam logic [15:0]       INTERVAL_RESET = 16'd100;
	localparam logic [6:0]        PCT_MAX        = 7'd100;

	typedef struct packed {
		cmd_t              cmd;
		logic signed [7:0] rssi_dbm;
		logic [7:0]        sync_uid3;
		logic [7:0]        sync_uid4;
		logic [7:0]        sync_uid5;
		logic              dwell_got;
		logic [31:0]       now_ms;
	} evt_t;

	typedef struct packed {
		logic signed [7:0] envelope_rssi;
		logic [6:0]        link_quality_pct;
		logic [31:0]       report_time_ms;
	} rpt_t;

	typedef struct packed {
		logic [3:0]  index;
		logic [15:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0]        uid3;
		logic [7:0]        uid4;
		logic [7:0]        uid5;
		logic [7:0]        mask;
		logic signed [7:0] floor;
		logic [6:0]        decay;
		logic [15:0]       gate;
		logic [15:0]       interval;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic clear;
		logic got;
	} win_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/tre_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tre_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// -----------------------------------------------------------------------------
interface tre_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/tre_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tre_cfg_regs: configuration register file
// Takes one register write per transaction; writes to unknown indexes are
// dropped and values are cut to the register width.
// -----------------------------------------------------------------------------
module tre_cfg_regs
	import tre_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	tre_stream_if.sink    cfg,
	output cfg_t          regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.uid3     <= 8'd0;
			regs_q.uid4     <= 8'd0;
			regs_q.uid5     <= 8'd0;
			regs_q.mask     <= MASK_RESET;
			regs_q.floor    <= FLOOR_RESET;
			regs_q.decay    <= DECAY_RESET;
			regs_q.gate     <= GATE_RESET;
			regs_q.interval <= INTERVAL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_UID3:     regs_q.uid3     <= cfg.data.wdata[7:0];
				REG_UID4:     regs_q.uid4     <= cfg.data.wdata[7:0];
				REG_UID5:     regs_q.uid5     <= cfg.data.wdata[7:0];
				REG_MASK:     regs_q.mask     <= cfg.data.wdata[7:0];
				REG_FLOOR:    regs_q.floor    <= cfg.data.wdata[7:0];
				REG_DECAY:    regs_q.decay    <= cfg.data.wdata[6:0];
				REG_GATE:     regs_q.gate     <= cfg.data.wdata;
				REG_INTERVAL: regs_q.interval <= cfg.data.wdata;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tre_window.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tre_window: sliding window of dwell outcomes
// A shift line of the last DWELLS outcomes with a running hit count, and the
// hit percentage of the window as it stands after the current push.
// -----------------------------------------------------------------------------
module tre_window
	import tre_pkg::*;
#(
	parameter int DWELLS = 50
) (
	input  logic       clk,
	input  logic       arst_n,
	input  win_ctl_t   ctl,
	output logic [6:0] pct_after
);

	localparam int HW    = $clog2(DWELLS + 1);
	localparam int SH    = 24;
	localparam int KW    = 31;
	localparam logic [KW-1:0] PCT_K =
		KW'((64'd100 * (64'd1 << SH) + 64'(DWELLS) - 64'd1) / 64'(DWELLS));

	logic [DWELLS-1:0] win_q;
	logic [HW-1:0]     hits_q;
	logic [HW-1:0]     hits_after;
	logic [DWELLS:0]   win_shift;
	logic [HW+KW-1:0]  pct_prod;

	assign win_shift  = {win_q, ctl.got};
	assign hits_after = ctl.push
		? HW'(hits_q - HW'(win_q[DWELLS-1]) + HW'(ctl.got))
		: hits_q;
	assign pct_prod   = (HW+KW)'(hits_after) * (HW+KW)'(PCT_K);
	assign pct_after  = pct_prod[SH +: 7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			hits_q <= '0;
		end else if (ctl.clear) begin
			win_q  <= '0;
			hits_q <= '0;
		end else if (ctl.push) begin
			win_q  <= win_shift[DWELLS-1:0];
			hits_q <= hits_after;
		end
	end

`ifndef SYNTHESIS
	a_hits_match: assert property (@(posedge clk) disable iff (!arst_n)
		HW'($countones(win_q)) == hits_q)
		else $error("window hit count does not match stored outcomes");
`endif

endmodule
`default_nettype wire

FILE: hdl/telemetry_rssi_envelope_and_lq.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: the input stage registers the dwell end, then rpt_data_q its report.
// Throughput: one event per cycle; an input stage and a report register let the
// next event enter while a report waits, and a report-producing event stalls
// only when the report register is still full.
// Reset: arst_n clears all state but the event and report data at once; no sweep
// follows and events are taken from the first cycle after reset.
// -----------------------------------------------------------------------------
// telemetry_rssi_envelope_and_lq: RSSI envelope and link quality monitor
// Tracks peak telemetry RSSI, sync identity matches and dwell outcomes, and
// on each due dwell end emits the envelope and the window hit percentage.
// -----------------------------------------------------------------------------
module telemetry_rssi_envelope_and_lq
	import tre_pkg::*;
#(
	parameter int WINDOW_DWELLS = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	tre_stream_if.sink   cfg,
	tre_stream_if.sink   evt,
	tre_stream_if.source rpt
);

	cfg_t     regs;
	win_ctl_t win_ctl;
	logic [6:0] pct_after;

	logic  s1_valid_q;
	evt_t  evt_s1;

	logic signed [7:0] peak_q;
	logic              seen_q;
	logic signed [7:0] env_q;
	logic [31:0]       last_q;
	logic [31:0]       sync_time_q;
	logic              sync_valid_q;

	logic  rpt_valid_q;
	rpt_t  rpt_data_q;

	logic              due;
	logic              report;
	logic              out_free;
	logic              advance;
	logic              trusted;
	logic              uid_match;
	logic signed [7:0] rssi_s1;
	logic signed [7:0] target;
	logic signed [8:0] env_dec;
	logic signed [8:0] env_sel;
	logic signed [7:0] env_new;

	tre_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tre_window #(
		.DWELLS (WINDOW_DWELLS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (win_ctl),
		.pct_after (pct_after)
	);

	assign rssi_s1  = evt_s1.rssi_dbm;
	assign due      = (evt_s1.now_ms - last_q) >= {16'd0, regs.interval};
	assign report   = s1_valid_q && (evt_s1.cmd == CMD_DWELL_END) && due;
	assign out_free = !rpt_valid_q || rpt.ready;
	assign advance  = s1_valid_q && (!report || out_free);
	assign evt.ready = !s1_valid_q || advance;

	assign win_ctl.push  = advance && (evt_s1.cmd == CMD_DWELL_END);
	assign win_ctl.clear = advance && (evt_s1.cmd == CMD_RESTART);
	assign win_ctl.got   = evt_s1.dwell_got;

	assign trusted   = sync_valid_q && ((evt_s1.now_ms - sync_time_q) < {16'd0, regs.gate});
	assign target    = (trusted && seen_q) ? peak_q : regs.floor;
	assign uid_match = (evt_s1.sync_uid3 == regs.uid3) && (evt_s1.sync_uid4 == regs.uid4)
		&& (((evt_s1.sync_uid5 ^ regs.uid5) & regs.mask) == 8'd0);

	always_comb begin
		env_dec = 9'(signed'(env_q)) - signed'({2'b00, regs.decay});
		env_sel = env_dec;
		if (env_sel < 9'(signed'(target))) begin
			env_sel = 9'(signed'(target));
		end
		if (env_sel < 9'(signed'(regs.floor))) begin
			env_sel = 9'(signed'(regs.floor));
		end
		if (target > env_q) begin
			env_new = target;
		end else begin
			env_new = env_sel[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt.ready) begin
			s1_valid_q <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q       <= FLOOR_RESET;
			seen_q       <= 1'b0;
			env_q        <= FLOOR_RESET;
			last_q       <= 32'd0;
			sync_time_q  <= 32'd0;
			sync_valid_q <= 1'b0;
		end else if (advance) begin
			unique case (evt_s1.cmd)
				CMD_TELEMETRY: begin
					if (rssi_s1 > peak_q) begin
						peak_q <= rssi_s1;
					end
					seen_q <= 1'b1;
				end
				CMD_SYNC: begin
					if (uid_match) begin
						sync_time_q  <= evt_s1.now_ms;
						sync_valid_q <= 1'b1;
					end
				end
				CMD_DWELL_END: begin
					if (due) begin
						env_q  <= env_new;
						peak_q <= regs.floor;
						seen_q <= 1'b0;
						last_q <= evt_s1.now_ms;
					end
				end
				CMD_RESTART: begin
					sync_time_q  <= 32'd0;
					sync_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (report && advance) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report && advance) begin
			rpt_data_q.envelope_rssi    <= env_new;
			rpt_data_q.link_quality_pct <= pct_after;
			rpt_data_q.report_time_ms   <= evt_s1.now_ms;
		end
	end

	assign rpt.valid = rpt_valid_q;
	assign rpt.data  = rpt_data_q;

`ifndef SYNTHESIS
	a_stall_only_on_report: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |-> report)
		else $error("input stage stalled without a pending report");
	a_report_stamps_time: assert property (@(posedge clk) disable iff (!arst_n)
		(report && advance) |=> (last_q == rpt_data_q.report_time_ms))
		else $error("report time and last report time disagree");
	a_pct_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid_q |-> (rpt_data_q.link_quality_pct <= PCT_MAX))
		else $error("link quality above one hundred percent");
	a_restart_clears_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (evt_s1.cmd == CMD_RESTART)) |=> !sync_valid_q)
		else $error("sync stamp survived a restart");
`endif

endmodule
`default_nettype wire
